/* rtl/bcus_pkg.sv */
// ----------------------------------------------------------------------------
// Byte count unit scaler package
// Shared widths, mode codes, the result record and the unit size table.
// ----------------------------------------------------------------------------
`default_nettype none

package bcus_pkg;

  // Field widths.
  localparam int unsigned COUNT_W = 64;
  localparam int unsigned SHOWN_W = 14;
  localparam int unsigned UNIT_W  = 3;
  localparam int unsigned MODE_W  = 2;

  // Unit base mode codes; any other code selects base 1000.
  localparam logic [MODE_W-1:0] MODE_1024_BIN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_1024_DEC = 2'd1;

  // Unit indexes and display bases.
  localparam logic [UNIT_W-1:0]  UNIT_BYTE = 3'd0;
  localparam logic [UNIT_W-1:0]  UNIT_TOP  = 3'd5;
  localparam logic [SHOWN_W-1:0] BASE_BIN  = 14'd1024;
  localparam logic [SHOWN_W-1:0] BASE_DEC  = 14'd1000;

  // One finished result.
  typedef struct packed {
    logic [SHOWN_W-1:0] shown_value;
    logic [UNIT_W-1:0]  unit_index;
    logic               binary_labels;
    logic [COUNT_W-1:0] rounded_bytes;
  } bcus_result_t;

  // Size of one unit in bytes, for base 1024 or base 1000.
  function automatic logic [COUNT_W-1:0] unit_size(input logic base_dec,
                                                   input logic [UNIT_W-1:0] unit);
    logic [COUNT_W-1:0] size;
    size = '0;
    case (unit)
      3'd0: size = 64'd1;
      3'd1: size = base_dec ? 64'd1000             : 64'd1024;
      3'd2: size = base_dec ? 64'd1000000          : 64'd1048576;
      3'd3: size = base_dec ? 64'd1000000000       : 64'd1073741824;
      3'd4: size = base_dec ? 64'd1000000000000    : 64'd1099511627776;
      3'd5: size = base_dec ? 64'd1000000000000000 : 64'd1125899906842624;
      default: size = '0;
    endcase
    return size;
  endfunction

  // Ten units in bytes, the divisor when the value is shown to tens.
  function automatic logic [COUNT_W-1:0] tens_size(input logic base_dec,
                                                   input logic [UNIT_W-1:0] unit);
    return COUNT_W'(64'd10 * unit_size(base_dec, unit));
  endfunction

endpackage

`default_nettype wire

/* rtl/bcus_engine.sv */
// ----------------------------------------------------------------------------
// Byte count unit scaler engine
// Sequencer around one shared 64-bit adder: unit search, restoring division,
// rounding and a shift-add multiply that rebuilds the rounded byte count.
// ----------------------------------------------------------------------------
`default_nettype none

module bcus_engine (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [bcus_pkg::COUNT_W-1:0]   count,
  input  wire logic [bcus_pkg::MODE_W-1:0]    mode,
  output logic                                ready,
  output logic                                done,
  input  wire logic                           take,
  output bcus_pkg::bcus_result_t              result
);
  import bcus_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SEARCH = 8'b0000_0010,
    ST_TENS   = 8'b0000_0100,
    ST_DIV    = 8'b0000_1000,
    ST_ROUND  = 8'b0001_0000,
    ST_CARRY  = 8'b0010_0000,
    ST_MUL    = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_t;

  localparam logic [5:0] DIV_LAST  = 6'(COUNT_W - 1);
  localparam logic [5:0] MUL_FIRST = 6'(SHOWN_W - 1);

  state_t              state;
  logic [COUNT_W-1:0]  count_r;
  logic [COUNT_W-1:0]  quo;
  logic [COUNT_W-1:0]  rem;
  logic [COUNT_W-1:0]  divisor;
  logic [COUNT_W-1:0]  acc;
  logic [SHOWN_W-1:0]  shown;
  logic [UNIT_W-1:0]   unit;
  logic [5:0]          step;
  logic                tens;
  logic                base_dec;
  logic                binary;

  logic [COUNT_W-1:0]  alu_a;
  logic [COUNT_W-1:0]  alu_b;
  logic                alu_sub;
  logic [COUNT_W:0]    alu_sum;
  logic                alu_carry;
  logic [COUNT_W-1:0]  rem_shift;
  logic [UNIT_W-1:0]   unit_up;
  logic [SHOWN_W-1:0]  base_val;
  logic [SHOWN_W-1:0]  q_up;
  logic [SHOWN_W-1:0]  shown_round;

  assign rem_shift = {rem[COUNT_W-2:0], quo[COUNT_W-1]};
  assign unit_up   = unit + 3'd1;
  assign base_val  = base_dec ? BASE_DEC : BASE_BIN;

  // Operand selection for the shared adder, one use per state.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      ST_SEARCH: begin
        alu_a   = count_r;
        alu_b   = unit_size(base_dec, unit_up);
        alu_sub = 1'b1;
      end
      ST_TENS: begin
        alu_a   = count_r;
        alu_b   = tens_size(base_dec, unit);
        alu_sub = 1'b1;
      end
      ST_DIV: begin
        alu_a   = rem_shift;
        alu_b   = divisor;
        alu_sub = 1'b1;
      end
      ST_ROUND: begin
        alu_a   = {rem[COUNT_W-2:0], 1'b0};
        alu_b   = divisor;
        alu_sub = 1'b1;
      end
      ST_MUL: begin
        alu_a   = {acc[COUNT_W-2:0], 1'b0};
        alu_b   = shown[step[3:0]] ? unit_size(base_dec, unit) : '0;
        alu_sub = 1'b0;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  // Shared adder; on a subtract the carry out means a is not below b.
  assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                   + {{COUNT_W{1'b0}}, alu_sub};
  assign alu_carry = alu_sum[COUNT_W];

  // Round half up on the quotient: twice the remainder against the divisor.
  assign q_up        = quo[SHOWN_W-1:0] + {{(SHOWN_W-1){1'b0}}, alu_carry};
  assign shown_round = tens ? SHOWN_W'((q_up << 3) + (q_up << 1)) : q_up;

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            count_r  <= count;
            base_dec <= !(mode inside {MODE_1024_BIN, MODE_1024_DEC});
            binary   <= (mode == MODE_1024_BIN);
            unit     <= UNIT_BYTE;
            if (count == '0 || count[COUNT_W-1]) begin
              shown <= '0;
              acc   <= '0;
              state <= ST_DONE;
            end else begin
              state <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          // Step up while the next unit still fits in the count.
          if (unit != UNIT_TOP && alu_carry) begin
            unit <= unit_up;
          end else if (unit == UNIT_BYTE) begin
            shown <= count_r[SHOWN_W-1:0];
            acc   <= count_r;
            state <= ST_DONE;
          end else begin
            state <= ST_TENS;
          end
        end
        ST_TENS: begin
          tens    <= alu_carry;
          divisor <= alu_carry ? tens_size(base_dec, unit) : unit_size(base_dec, unit);
          rem     <= '0;
          quo     <= count_r;
          step    <= '0;
          state   <= ST_DIV;
        end
        ST_DIV: begin
          // One restoring division step per cycle.
          quo  <= {quo[COUNT_W-2:0], alu_carry};
          rem  <= alu_carry ? alu_sum[COUNT_W-1:0] : rem_shift;
          step <= step + 6'd1;
          if (step == DIV_LAST) begin
            state <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          shown <= shown_round;
          state <= ST_CARRY;
        end
        ST_CARRY: begin
          // A value that rounds up to the base or beyond, below the top unit,
          // becomes one of the next unit.
          if (unit != UNIT_TOP && shown >= base_val) begin
            shown <= {{(SHOWN_W-1){1'b0}}, 1'b1};
            unit  <= unit_up;
          end
          acc   <= '0;
          step  <= MUL_FIRST;
          state <= ST_MUL;
        end
        ST_MUL: begin
          // Shift-add multiply of the shown value by the unit size.
          acc  <= alu_sum[COUNT_W-1:0];
          step <= step - 6'd1;
          if (step == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign ready  = (state == ST_IDLE);
  assign done   = (state == ST_DONE);
  assign result = '{shown_value:   shown,
                    unit_index:    unit,
                    binary_labels: binary,
                    rounded_bytes: acc};

endmodule

`default_nettype wire

/* rtl/byte_count_unit_scaler_top.sv */
// ----------------------------------------------------------------------------
// Byte count unit scaler
// Scales a signed byte count to a display value in B, K, M, G, T or P units.
// ----------------------------------------------------------------------------
// A request carries one signed 64-bit byte count and gives one result: the
// rounded value to show, the unit index, the label style flag and the rounded
// count in bytes. A count of zero or less goes from the accepting step straight
// to the done state; a count below one kilo unit takes one search step first.
// A scaled count takes the accepting step, up to six unit search steps, one
// tens compare, 64 restoring division steps, one rounding step, one carry step
// and a 14-step shift-add multiply; all but the accepting and carry steps use
// the single shared 64-bit adder. The done state hands the result to the output
// register. The engine handles one request at a time; the output register lets
// it take the next request while a result still waits. The user must write
// unit_base_mode only while no request is in flight; the block does not enforce it.
`default_nettype none

module byte_count_unit_scaler_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write_enable,
  input  wire logic [bcus_pkg::MODE_W-1:0]       cfg_write_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [bcus_pkg::COUNT_W-1:0] byte_count,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [bcus_pkg::SHOWN_W-1:0]           shown_value,
  output logic [bcus_pkg::UNIT_W-1:0]            unit_index,
  output logic                                   binary_labels,
  output logic [bcus_pkg::COUNT_W-1:0]           rounded_bytes
);
  import bcus_pkg::*;

  logic [MODE_W-1:0] unit_base_mode;
  logic              eng_ready;
  logic              eng_done;
  logic              eng_take;
  bcus_result_t      eng_result;
  bcus_result_t      out_r;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_base_mode <= '0;
    end else if (cfg_write_enable) begin
      unit_base_mode <= cfg_write_data;
    end
  end

  // A request enters only when the engine is idle.
  assign in_stall = !eng_ready;

  bcus_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .start  (in_valid && eng_ready),
    .count  ($unsigned(byte_count)),
    .mode   (unit_base_mode),
    .ready  (eng_ready),
    .done   (eng_done),
    .take   (eng_take),
    .result (eng_result)
  );

  // Output register: loads when empty or when its result is taken.
  assign eng_take = eng_done && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (eng_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_take) begin
      out_r <= eng_result;
    end
  end

  assign shown_value   = out_r.shown_value;
  assign unit_index    = out_r.unit_index;
  assign binary_labels = out_r.binary_labels;
  assign rounded_bytes = out_r.rounded_bytes;

endmodule

`default_nettype wire

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// Byte count unit scaler testbench
// Sends signed byte counts and checks the scaled value, unit, label style and
// rounded byte count against a predictor, under all unit base modes.
// ----------------------------------------------------------------------------
// A scoreboard computes the expected result when a request is accepted and
// compares every result that leaves the block with the oldest expectation.
// Both sides idle at random. One phase holds off the result side for a long
// stretch so that the block fills up and stalls its input.

module testbench;
  import bcus_pkg::*;

  // Mode codes above the two base 1024 ones both select base 1000.
  localparam logic [MODE_W-1:0] MODE_1000     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_1000_ALT = 2'd3;

  localparam int unsigned PHASE_ITEMS  = 150;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    bcus_result_t       want;
  } scaled_request_t;

  // Predicts each result and matches it with the block's output.
  class scale_board;
    scaled_request_t pending_q[$];
    logic [MODE_W-1:0] mode;
    int unsigned mismatch_count;

    function new();
      mode = MODE_1024_BIN;
      mismatch_count = 0;
    endfunction

    function void set_mode(logic [MODE_W-1:0] m);
      mode = m;
    endfunction

    function int unsigned pending();
      return pending_q.size();
    endfunction

    // Integer division that rounds an exact half upward.
    function logic [COUNT_W-1:0] round_half_up(logic [COUNT_W-1:0] num,
                                               logic [COUNT_W-1:0] den);
      logic [COUNT_W-1:0] q;
      logic [COUNT_W-1:0] r;
      q = num / den;
      r = num % den;
      if (r >= den - r) begin
        q = q + 64'd1;
      end
      return q;
    endfunction

    function bcus_result_t scale_count(logic [COUNT_W-1:0] count);
      bcus_result_t res;
      logic [COUNT_W-1:0] base;
      logic [COUNT_W-1:0] factor;
      logic [COUNT_W-1:0] num;
      logic [COUNT_W-1:0] den;
      logic [COUNT_W-1:0] shown;
      logic [UNIT_W-1:0] unit;
      bit settled;
      base = (mode == MODE_1024_BIN || mode == MODE_1024_DEC) ? 64'd1024 : 64'd1000;
      res = '0;
      res.binary_labels = (mode == MODE_1024_BIN);
      shown = '0;
      factor = 64'd1;
      unit = UNIT_BYTE;
      // Zero and negative counts show as zero bytes.
      if (count != '0 && !count[COUNT_W-1]) begin
        while (unit < UNIT_TOP && count >= factor * base) begin
          factor = factor * base;
          unit = unit + 1'b1;
        end
        if (unit == UNIT_BYTE) begin
          shown = count;
        end else begin
          num = count;
          den = factor;
          settled = 1'b0;
          // A value that rounds up to the base moves on to the next unit.
          while (!settled) begin
            if (num >= 64'd10 * den) begin
              shown = round_half_up(num, 64'd10 * den) * 64'd10;
            end else begin
              shown = round_half_up(num, den);
            end
            if (unit < UNIT_TOP && shown >= base) begin
              num = shown;
              den = base;
              factor = factor * base;
              unit = unit + 1'b1;
            end else begin
              settled = 1'b1;
            end
          end
        end
        res.rounded_bytes = shown * factor;
      end
      res.shown_value = shown[SHOWN_W-1:0];
      res.unit_index = unit;
      return res;
    endfunction

    function void note_request(logic [COUNT_W-1:0] count);
      scaled_request_t req;
      req.count = count;
      req.want = scale_count(count);
      pending_q.push_back(req);
    endfunction

    function void report(string what, scaled_request_t req, bcus_result_t got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("%s: count=%h mode=%0d expected shown=%0d unit=%0d bin=%0d bytes=%0d",
                 what, req.count, mode, req.want.shown_value, req.want.unit_index,
                 req.want.binary_labels, req.want.rounded_bytes);
        $display("  got shown=%0d unit=%0d bin=%0d bytes=%0d", got.shown_value,
                 got.unit_index, got.binary_labels, got.rounded_bytes);
      end
    endfunction

    function void check_result(bcus_result_t got);
      scaled_request_t req;
      if (pending_q.size() == 0) begin
        report("result with no request pending", '0, got);
        return;
      end
      req = pending_q.pop_front();
      if (got.shown_value !== req.want.shown_value ||
          got.unit_index !== req.want.unit_index ||
          got.binary_labels !== req.want.binary_labels ||
          got.rounded_bytes !== req.want.rounded_bytes) begin
        report("result mismatch", req, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_write_enable;
  logic [MODE_W-1:0] cfg_write_data;
  logic in_valid;
  logic in_stall;
  logic signed [COUNT_W-1:0] byte_count;
  logic out_valid;
  logic out_stall;
  logic [SHOWN_W-1:0] shown_value;
  logic [UNIT_W-1:0] unit_index;
  logic binary_labels;
  logic [COUNT_W-1:0] rounded_bytes;

  scale_board board;
  bit receiver_stalls_on = 1'b1;
  bit long_hold_due = 1'b0;
  int unsigned cycle_count = 0;

  logic [COUNT_W-1:0] directed_counts [12] = '{
    64'd0,
    64'hFFFF_FFFF_FFFF_FFFF,
    64'h8000_0000_0000_0000,
    64'h7FFF_FFFF_FFFF_FFFF,
    64'd1,
    64'd999,
    64'd1023,
    64'd1024,
    64'd1536,
    64'd15360,
    64'd999500,
    64'd1125899906842624
  };

  logic [MODE_W-1:0] phase_modes [5] = '{
    MODE_1024_DEC, MODE_1000_ALT, MODE_1024_BIN, MODE_1000, MODE_1024_DEC
  };

  byte_count_unit_scaler_top uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .byte_count       (byte_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .shown_value      (shown_value),
    .unit_index       (unit_index),
    .binary_labels    (binary_labels),
    .rounded_bytes    (rounded_bytes)
  );

  always #4 clk = ~clk;

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      return 0;
    end else if (sel < 85) begin
      return $urandom_range(1, 3);
    end else if (sel < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Byte counts spread over all units, with rounding edges and unit boundaries.
  function automatic logic [COUNT_W-1:0] pick_count();
    logic [COUNT_W-1:0] v;
    logic [COUNT_W-1:0] size;
    logic [COUNT_W-1:0] base;
    int unsigned sel;
    int unsigned k;
    sel = $urandom_range(0, 99);
    v = {$urandom, $urandom};
    if (sel < 6) begin
      v[COUNT_W-1] = 1'b1;
    end else if (sel < 9) begin
      v = '0;
    end else if (sel >= 22 && sel < 60) begin
      k = $urandom_range(1, 63);
      v = v >> (64 - k);
    end else if (sel >= 60) begin
      base = ($urandom_range(0, 1) == 1) ? 64'd1024 : 64'd1000;
      size = 64'd1;
      k = $urandom_range(1, 5);
      repeat (k) size = size * base;
      v = size * $urandom_range(1, 1023);
      case ($urandom_range(0, 5))
        0: v = v + (size >> 1);
        1: v = v + (size >> 1) - 64'd1;
        2: v = v - $urandom_range(0, 3);
        3: v = v + $urandom_range(0, 3);
        4: v = size * (64'd10 * $urandom_range(1, 102)) + size * 64'd5;
        default: v = size * base - (size >> $urandom_range(1, 12));
      endcase
    end
    return v;
  endfunction

  // Offers one request from a falling edge and holds it until accepted.
  task automatic send_count(input logic [COUNT_W-1:0] count, input int unsigned gap);
    in_valid <= 1'b1;
    byte_count <= count;
    do @(posedge clk); while (in_stall);
    board.note_request(count);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    while (board.pending() != 0) @(negedge clk);
  endtask

  task automatic write_mode(input logic [MODE_W-1:0] m);
    @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_write_data <= m;
    @(negedge clk);
    cfg_write_enable <= 1'b0;
    board.set_mode(m);
  endtask

  // Stimulus: directed counts in two modes, then random phases.
  initial begin : stimulus
    int unsigned n;
    int unsigned p;
    bit sender_gaps_on;
    board = new();
    rst = 1'b1;
    in_valid = 1'b0;
    byte_count = '0;
    cfg_write_enable = 1'b0;
    cfg_write_data = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    foreach (directed_counts[i]) send_count(directed_counts[i], pick_gap());
    in_valid <= 1'b0;
    wait_drained();
    write_mode(MODE_1000);
    foreach (directed_counts[i]) send_count(directed_counts[i], pick_gap());
    for (p = 0; p < 5; p++) begin
      in_valid <= 1'b0;
      wait_drained();
      write_mode(phase_modes[p]);
      sender_gaps_on = (p != 1);
      receiver_stalls_on = (p != 2);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n == 20) begin
          long_hold_due = 1'b1;
        end
        send_count(pick_count(), sender_gaps_on ? pick_gap() : 0);
      end
    end
    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatch_count == 0 && board.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_due) begin
        stall_left = LONG_HOLD;
        long_hold_due = 1'b0;
      end
      if (stall_left == 0 && receiver_stalls_on) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Check every accepted result.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      board.check_result(bcus_result_t'({shown_value, unit_index, binary_labels,
                                         rounded_bytes}));
    end
  end

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
